[hdl/auto_exposure_gain_search_macros.svh]
// assertion macros shared by the auto exposure gain search rtl
// no dependencies; assertions use the enclosing module's clk_i and rst_ni
`ifndef AUTO_EXPOSURE_GAIN_SEARCH_MACROS_SVH
`define AUTO_EXPOSURE_GAIN_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define AEGS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("aegs assertion failed");
`define AEGS_ASSERT_NEVER(lbl, cond) `AEGS_ASSERT(lbl, !(cond))
`else
`define AEGS_ASSERT(lbl, prop)
`define AEGS_ASSERT_NEVER(lbl, cond)
`endif

`endif

[hdl/aegs_pkg.sv]
// shared types and constants for the auto exposure gain search block
// no dependencies
`default_nettype none

package aegs_pkg;

  localparam int unsigned GAIN_COUNT = 4;
  localparam logic [1:0]  GAIN_TOP   = 2'(GAIN_COUNT - 1);

  localparam logic [7:0] CODE_MIN = 8'h00;
  localparam logic [7:0] CODE_MAX = 8'hFF;
  localparam logic [7:0] CODE_MID = 8'h7F;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNTS = 2'd2;

  localparam logic [15:0] SETPOINT_RST   = 16'd20000;
  localparam logic [15:0] HYSTERESIS_RST = 16'd2000;
  localparam logic [15:0] MAX_COUNTS_RST = 16'd65535;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  typedef enum logic [2:0] {
    ST_ADJUST  = 3'd0,
    ST_SETTLED = 3'd1,
    ST_UNDER   = 3'd2,
    ST_BUSERR  = 3'd3,
    ST_IDLE    = 3'd4
  } status_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] clear_count;
    logic        bus_error;
  } item_t;

  typedef struct packed {
    logic [1:0] gain_index;
    logic [7:0] integration_code;
    status_e    status;
    logic       settled;
  } result_t;

endpackage

`default_nettype wire

[hdl/aegs_core.sv]
// exposure control state, configuration registers and single-step decision logic
// depends on aegs_pkg and auto_exposure_gain_search_macros.svh
`default_nettype none
`include "auto_exposure_gain_search_macros.svh"

module aegs_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [aegs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic                           step_i,
  input  wire aegs_pkg::item_t                item_i,
  output aegs_pkg::result_t                   result_o
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_GAIN   = 2'd1,
    PH_SEARCH = 2'd2
  } phase_e;

  logic [15:0] setpoint_q, hysteresis_q, max_counts_q;

  phase_e      ph_q, ph_d;
  logic [1:0]  gain_q, gain_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;
  logic        stable_q, stable_d;

  aegs_pkg::status_e st;
  logic [15:0] band_lo;
  logic [16:0] band_hi;
  logic        in_band;
  logic        too_bright;
  logic        done;
  logic [8:0]  bound_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= aegs_pkg::SETPOINT_RST;
      hysteresis_q <= aegs_pkg::HYSTERESIS_RST;
      max_counts_q <= aegs_pkg::MAX_COUNTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        aegs_pkg::CFG_SETPOINT:   setpoint_q   <= cfg_data_i;
        aegs_pkg::CFG_HYSTERESIS: hysteresis_q <= cfg_data_i;
        aegs_pkg::CFG_MAX_COUNTS: max_counts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // acceptance band, low edge clamped at zero, high edge kept at 17 bits
  assign band_lo    = (setpoint_q > hysteresis_q) ? (setpoint_q - hysteresis_q) : 16'd0;
  assign band_hi    = {1'b0, setpoint_q} + {1'b0, hysteresis_q};
  assign in_band    = (item_i.clear_count >= band_lo) && ({1'b0, item_i.clear_count} <= band_hi);
  assign too_bright = (item_i.clear_count >= max_counts_q) ||
                      ({1'b0, item_i.clear_count} > band_hi);

  always_comb begin
    ph_d      = ph_q;
    gain_d    = gain_q;
    code_d    = code_q;
    low_d     = low_q;
    high_d    = high_q;
    stable_d  = stable_q;
    st        = aegs_pkg::ST_ADJUST;
    done      = 1'b0;
    bound_sum = 9'd0;
    if (item_i.mode == aegs_pkg::MODE_START) begin
      gain_d   = 2'd0;
      code_d   = aegs_pkg::CODE_MIN;
      low_d    = aegs_pkg::CODE_MIN;
      high_d   = aegs_pkg::CODE_MAX;
      stable_d = 1'b0;
      if (item_i.bus_error) begin
        st   = aegs_pkg::ST_BUSERR;
        ph_d = PH_IDLE;
      end else begin
        ph_d = PH_GAIN;
      end
    end else begin
      case (ph_q)
        PH_GAIN: begin
          if (item_i.bus_error) begin
            st       = aegs_pkg::ST_BUSERR;
            ph_d     = PH_IDLE;
            stable_d = 1'b0;
          end else if (item_i.clear_count >= setpoint_q) begin
            if (in_band) begin
              st       = aegs_pkg::ST_SETTLED;
              ph_d     = PH_IDLE;
              stable_d = 1'b1;
            end else begin
              ph_d   = PH_SEARCH;
              low_d  = aegs_pkg::CODE_MIN;
              high_d = aegs_pkg::CODE_MAX;
              code_d = aegs_pkg::CODE_MID;
            end
          end else if (gain_q < aegs_pkg::GAIN_TOP) begin
            gain_d = gain_q + 2'd1;
          end else begin
            st       = aegs_pkg::ST_UNDER;
            ph_d     = PH_IDLE;
            stable_d = 1'b0;
          end
        end
        PH_SEARCH: begin
          if (item_i.bus_error) begin
            st       = aegs_pkg::ST_BUSERR;
            ph_d     = PH_IDLE;
            stable_d = 1'b0;
          end else if (in_band) begin
            st       = aegs_pkg::ST_SETTLED;
            ph_d     = PH_IDLE;
            stable_d = 1'b1;
          end else begin
            if (too_bright) begin
              if (code_q == aegs_pkg::CODE_MAX) begin
                done = 1'b1;
              end else begin
                low_d = code_q + 8'd1;
              end
            end else begin
              if (code_q == aegs_pkg::CODE_MIN) begin
                done = 1'b1;
              end else begin
                high_d = code_q - 8'd1;
              end
            end
            if (!done && (low_d > high_d)) begin
              done = 1'b1;
            end
            if (done) begin
              st       = aegs_pkg::ST_SETTLED;
              ph_d     = PH_IDLE;
              stable_d = 1'b1;
            end else begin
              bound_sum = {1'b0, low_d} + {1'b0, high_d};
              code_d    = bound_sum[8:1];
            end
          end
        end
        default: begin
          // measurement while idle leaves everything as it is
          st = aegs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      gain_q   <= 2'd0;
      code_q   <= aegs_pkg::CODE_MIN;
      low_q    <= aegs_pkg::CODE_MIN;
      high_q   <= aegs_pkg::CODE_MAX;
      stable_q <= 1'b0;
    end else if (step_i) begin
      ph_q     <= ph_d;
      gain_q   <= gain_d;
      code_q   <= code_d;
      low_q    <= low_d;
      high_q   <= high_d;
      stable_q <= stable_d;
    end
  end

  assign result_o.gain_index       = gain_d;
  assign result_o.integration_code = code_d;
  assign result_o.status           = st;
  assign result_o.settled          = stable_d;

  `AEGS_ASSERT(a_gain_range, gain_q <= aegs_pkg::GAIN_TOP)
  `AEGS_ASSERT(a_search_bounds, (ph_q == PH_SEARCH) |-> (low_q <= code_q && code_q <= high_q))
  `AEGS_ASSERT(a_abort_idle, (step_i && result_o.status == aegs_pkg::ST_BUSERR) |=> (ph_q == PH_IDLE))
  `AEGS_ASSERT(a_settled_status, (step_i && result_o.settled) |-> (result_o.status == aegs_pkg::ST_SETTLED || result_o.status == aegs_pkg::ST_IDLE))
  `AEGS_ASSERT_NEVER(a_idle_moves, step_i && result_o.status == aegs_pkg::ST_IDLE && (code_d != code_q || gain_d != gain_q))

endmodule

`default_nettype wire

[hdl/auto_exposure_gain_search.sv]
// top level of the auto exposure gain search: input register, decision core, result register
// depends on aegs_pkg and aegs_core
//
// usage
//   input channel: in_valid_i with mode_i, clear_count_i and bus_error_i; the block
//   raises in_stall_o to hold off a transfer. mode 0 starts a new adjustment, mode 1
//   delivers a clear-channel reading taken at the gain and code last reported.
//   output channel: out_valid_o with gain_index_o, integration_code_o, status_o and
//   settled_o; the receiver raises out_stall_i to hold a result.
//   every accepted item gives exactly one result, in order.
//   order: an item waits in the input register, its result then in the result register.
//   throughput: one item per cycle while out_stall_i is low, set by the input and result
//   registers advancing together; state is updated as an item enters the result register.
//   a stall on the output holds the result register; an empty input register still takes
//   one more item, then in_stall_o rises until the result is taken.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 setpoint,
//   1 hysteresis, 2 max_counts); write only while no item is in flight.
//   reset (rst_ni low, asynchronous): both registers empty, phase idle, gain and code 0,
//   configuration back to 20000, 2000 and 65535.
`default_nettype none

module auto_exposure_gain_search (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [aegs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           mode_i,
  input  wire logic [15:0]                    clear_count_i,
  input  wire logic                           bus_error_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          gain_index_o,
  output logic [7:0]                          integration_code_o,
  output logic [2:0]                          status_o,
  output logic                                settled_o
);

  logic              in_vld_q;
  aegs_pkg::item_t   in_item_q;
  logic              out_vld_q;
  aegs_pkg::result_t out_res_q;
  aegs_pkg::result_t core_res;

  logic out_free;
  logic advance;
  logic in_xfer;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_xfer || (in_vld_q && !advance);
      if (out_free) begin
        out_vld_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.mode        <= mode_i;
      in_item_q.clear_count <= clear_count_i;
      in_item_q.bus_error   <= bus_error_i;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  aegs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (advance),
    .item_i      (in_item_q),
    .result_o    (core_res)
  );

  assign out_valid_o        = out_vld_q;
  assign gain_index_o       = out_res_q.gain_index;
  assign integration_code_o = out_res_q.integration_code;
  assign status_o           = out_res_q.status;
  assign settled_o          = out_res_q.settled;

endmodule

`default_nettype wire
